// ----- hw/rtl/assert_macros.svh -----
// assertion helpers used by double_ended_queue
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every clock edge outside reset
`define DQ_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("deque assertion failed");

// condition that holds at every clock edge outside reset
`define DQ_ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("deque assertion failed");

`endif

// ----- hw/rtl/dq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_pkg
// Shared widths, request codes, status codes and command types of the deque.
// ----------------------------------------------------------------------------
package dq_pkg;

   localparam int unsigned DQ_CAPACITY   = 1024;
   localparam int unsigned DQ_DATA_WIDTH = 32;

   localparam int unsigned MODE_W   = 3;
   localparam int unsigned INDEX_W  = 11;
   localparam int unsigned VALUE_W  = 32;
   localparam int unsigned COUNT_W  = 11;
   localparam int unsigned STATUS_W = 2;

   // request modes
   localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
   localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_INSERT     = 3'd2;
   localparam logic [MODE_W-1:0] MODE_ERASE      = 3'd3;
   localparam logic [MODE_W-1:0] MODE_READ       = 3'd4;
   localparam logic [MODE_W-1:0] MODE_WRITE      = 3'd5;
   localparam logic [MODE_W-1:0] MODE_CLEAR      = 3'd6;

   // response status
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

   // request class; all zero is a no-op
   typedef struct packed {
      logic add;
      logic del;
      logic rd;
      logic wr;
      logic clr;
      logic at_front;
      logic at_back;
   } dq_kind_type;

   typedef struct packed {
      dq_kind_type         kind;
      logic [INDEX_W-1:0]  index;
      logic [VALUE_W-1:0]  value;
   } dq_cmd_type;

endpackage

// ----- hw/rtl/dq_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_if
// Request and response channels of the deque, valid/ready handshake.
// ----------------------------------------------------------------------------
interface dq_req_if;
   import dq_pkg::*;
   logic                       valid;
   logic                       ready;
   logic [MODE_W-1:0]          mode;
   logic [INDEX_W-1:0]         index;
   logic signed [VALUE_W-1:0]  value;
   modport source (output valid, mode, index, value, input ready);
   modport sink (input valid, mode, index, value, output ready);
endinterface

interface dq_rsp_if;
   import dq_pkg::*;
   logic                       valid;
   logic                       ready;
   logic signed [VALUE_W-1:0]  read_value;
   logic [COUNT_W-1:0]         count;
   logic [STATUS_W-1:0]        status;
   modport source (output valid, read_value, count, status, input ready);
   modport sink (input valid, read_value, count, status, output ready);
endinterface

// ----- hw/rtl/dq_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_front
// Accepts request words, classifies the mode and queues up to two commands.
// ----------------------------------------------------------------------------
module dq_front (
   input  logic               clock,
   input  logic               reset,
   dq_req_if.sink             req_if,
   output logic               cmd_valid,
   input  logic               cmd_ready,
   output dq_pkg::dq_cmd_type cmd
);
   import dq_pkg::*;

   dq_cmd_type q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   dq_cmd_type entry;
   logic       push, pop;

   // handshakes
   assign req_if.ready = (fill_ff != 2'd2);
   assign cmd_valid    = (fill_ff != 2'd0);
   assign push         = req_if.valid && req_if.ready;
   assign pop          = cmd_valid && cmd_ready;
   assign cmd          = q_ff[rd_ptr_ff];

   // classify the mode
   always_comb begin
      entry       = '0;
      entry.index = req_if.index;
      entry.value = req_if.value;
      case (req_if.mode)
         MODE_PUSH_FRONT: begin
            entry.kind.add      = 1'b1;
            entry.kind.at_front = 1'b1;
         end
         MODE_PUSH_BACK: begin
            entry.kind.add     = 1'b1;
            entry.kind.at_back = 1'b1;
         end
         MODE_INSERT: entry.kind.add = 1'b1;
         MODE_ERASE:  entry.kind.del = 1'b1;
         MODE_READ:   entry.kind.rd  = 1'b1;
         MODE_WRITE:  entry.kind.wr  = 1'b1;
         MODE_CLEAR:  entry.kind.clr = 1'b1;
         default:     entry.kind     = '0;
      endcase
   end

   // queue pointers and fill
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= entry;
      end
   end

endmodule

// ----- hw/rtl/dq_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_back
// Checks commands against the held range, shifts elements one per cycle
// through the circular store and drives the response register.
// ----------------------------------------------------------------------------
module dq_back #(
   parameter int unsigned CAPACITY   = dq_pkg::DQ_CAPACITY,
   parameter int unsigned DATA_WIDTH = dq_pkg::DQ_DATA_WIDTH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              cmd_valid,
   output logic                              cmd_ready,
   input  dq_pkg::dq_cmd_type                cmd,
   dq_rsp_if.source                          rsp_if,
   output logic [$clog2(CAPACITY+1)-1:0]     occupancy
);
   import dq_pkg::*;

   localparam int unsigned AW = $clog2(CAPACITY);
   localparam int unsigned CW = $clog2(CAPACITY + 1);
   localparam int unsigned XW = ((CW > INDEX_W) ? CW : INDEX_W) + 1;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_LOOK  = 2'd1;
   localparam logic [1:0] S_SHIFT = 2'd2;
   localparam logic [1:0] S_FIN   = 2'd3;

   // circular address helpers
   function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a, input logic [AW-1:0] b);
      logic [AW:0] s;
      s = {1'b0, a} + {1'b0, b};
      return (s >= (AW+1)'(CAPACITY)) ? AW'(s - (AW+1)'(CAPACITY)) : AW'(s);
   endfunction

   function automatic logic [AW-1:0] inc(input logic [AW-1:0] a);
      return (a == AW'(CAPACITY - 1)) ? '0 : a + AW'(1);
   endfunction

   function automatic logic [AW-1:0] dec(input logic [AW-1:0] a);
      return (a == '0) ? AW'(CAPACITY - 1) : a - AW'(1);
   endfunction

   function automatic logic [VALUE_W-1:0] widen(input logic [DATA_WIDTH-1:0] d);
      return VALUE_W'(signed'(d));
   endfunction

   logic [DATA_WIDTH-1:0] mem [CAPACITY];
   logic [DATA_WIDTH-1:0] rdata_ff;
   logic                  re, we;
   logic [AW-1:0]         raddr, waddr;
   logic [DATA_WIDTH-1:0] wdata;

   logic [1:0]            state_ff, state_in;
   logic [AW-1:0]         head_ff, head_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [AW-1:0]         src_ff, src_in, dst_ff, dst_in, fin_addr_ff, fin_addr_in;
   logic                  up_ff, up_in, pend_ff, pend_in, fin_wr_ff, fin_wr_in;
   logic                  rd_only_ff, rd_only_in;
   logic [CW-1:0]         left_ff, left_in;
   logic [DATA_WIDTH-1:0] fin_val_ff, fin_val_in;
   logic [VALUE_W-1:0]    res_ff, res_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0]    rsp_val_ff, rsp_val_in;
   logic [COUNT_W-1:0]    rsp_cnt_ff, rsp_cnt_in;
   logic [STATUS_W-1:0]   rsp_st_ff, rsp_st_in;

   // command decode terms
   logic [XW-1:0]         cnt_x, idx_x, pos_x;
   logic                  full, empty, add_front, del_front;
   logic [AW-1:0]         pos_a, idx_a, cnt_a, head_dec, addr_idx, add_dst;
   logic [DATA_WIDTH-1:0] val_store;

   assign cmd_ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign occupancy = count_ff;

   always_comb begin
      cnt_x     = XW'(count_ff);
      idx_x     = XW'(cmd.index);
      pos_x     = cmd.kind.at_front ? '0 : (cmd.kind.at_back ? cnt_x : idx_x);
      full      = (count_ff == CW'(CAPACITY));
      empty     = (count_ff == '0);
      add_front = ((pos_x << 1) < cnt_x);
      del_front = (((idx_x << 1) + XW'(1)) < cnt_x);
      pos_a     = AW'(pos_x);
      idx_a     = AW'(idx_x);
      cnt_a     = AW'(count_ff);
      head_dec  = dec(head_ff);
      addr_idx  = wrap_add(head_ff, idx_a);
      add_dst   = wrap_add(head_ff, cnt_a);
      val_store = DATA_WIDTH'($unsigned(cmd.value));
   end

   // sequencer
   always_comb begin
      state_in    = state_ff;
      head_in     = head_ff;
      count_in    = count_ff;
      src_in      = src_ff;
      dst_in      = dst_ff;
      up_in       = up_ff;
      pend_in     = pend_ff;
      left_in     = left_ff;
      fin_addr_in = fin_addr_ff;
      fin_wr_in   = fin_wr_ff;
      fin_val_in  = fin_val_ff;
      rd_only_in  = rd_only_ff;
      res_in      = res_ff;
      re          = 1'b0;
      raddr       = addr_idx;
      we          = 1'b0;
      waddr       = addr_idx;
      wdata       = val_store;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_val_in   = rsp_val_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      rsp_st_in    = rsp_st_ff;

      case (state_ff)
         S_IDLE: begin
            if (cmd_valid && cmd_ready) begin
               rsp_val_in = '0;
               rsp_st_in  = ST_OK;
               rsp_cnt_in = COUNT_W'(count_ff);
               if (cmd.kind.add) begin
                  if (full) begin
                     rsp_st_in    = ST_FULL;
                     rsp_valid_in = 1'b1;
                  end else if (pos_x > cnt_x) begin
                     rsp_st_in    = ST_RANGE;
                     rsp_valid_in = 1'b1;
                  end else begin
                     count_in   = count_ff + CW'(1);
                     fin_wr_in  = 1'b1;
                     fin_val_in = val_store;
                     res_in     = widen(val_store);
                     pend_in    = 1'b0;
                     if (add_front) begin
                        head_in     = head_dec;
                        left_in     = CW'(pos_x);
                        dst_in      = head_dec;
                        src_in      = inc(head_dec);
                        up_in       = 1'b1;
                        fin_addr_in = wrap_add(head_dec, pos_a);
                        state_in    = (pos_x == '0) ? S_FIN : S_SHIFT;
                     end else begin
                        left_in     = CW'(cnt_x - pos_x);
                        dst_in      = add_dst;
                        src_in      = dec(add_dst);
                        up_in       = 1'b0;
                        fin_addr_in = wrap_add(head_ff, pos_a);
                        state_in    = (pos_x == cnt_x) ? S_FIN : S_SHIFT;
                     end
                  end
               end else if (cmd.kind.del || cmd.kind.rd || cmd.kind.wr) begin
                  if (empty) begin
                     rsp_st_in    = ST_EMPTY;
                     rsp_valid_in = 1'b1;
                  end else if (idx_x >= cnt_x) begin
                     rsp_st_in    = ST_RANGE;
                     rsp_valid_in = 1'b1;
                  end else if (cmd.kind.wr) begin
                     we           = 1'b1;
                     rsp_val_in   = widen(val_store);
                     rsp_valid_in = 1'b1;
                  end else begin
                     re         = 1'b1;
                     rd_only_in = cmd.kind.rd;
                     fin_wr_in  = 1'b0;
                     pend_in    = 1'b0;
                     dst_in     = addr_idx;
                     state_in   = S_LOOK;
                     if (cmd.kind.del) begin
                        count_in = count_ff - CW'(1);
                        if (del_front) begin
                           left_in = CW'(idx_x);
                           src_in  = dec(addr_idx);
                           up_in   = 1'b0;
                           head_in = inc(head_ff);
                        end else begin
                           left_in = CW'(cnt_x - idx_x - XW'(1));
                           src_in  = inc(addr_idx);
                           up_in   = 1'b1;
                        end
                     end
                  end
               end else if (cmd.kind.clr) begin
                  count_in     = '0;
                  head_in      = '0;
                  rsp_cnt_in   = '0;
                  rsp_valid_in = 1'b1;
               end else begin
                  rsp_valid_in = 1'b1;
               end
            end
         end
         S_LOOK: begin
            res_in = widen(rdata_ff);
            if (rd_only_ff) begin
               rsp_val_in   = widen(rdata_ff);
               rsp_st_in    = ST_OK;
               rsp_cnt_in   = COUNT_W'(count_ff);
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else begin
               state_in = (left_ff == '0) ? S_FIN : S_SHIFT;
            end
         end
         S_SHIFT: begin
            // read one element ahead, write the one read last cycle
            pend_in = (left_ff != '0);
            if (left_ff != '0) begin
               re      = 1'b1;
               raddr   = src_ff;
               src_in  = up_ff ? inc(src_ff) : dec(src_ff);
               left_in = left_ff - CW'(1);
            end
            if (pend_ff) begin
               we     = 1'b1;
               waddr  = dst_ff;
               wdata  = rdata_ff;
               dst_in = up_ff ? inc(dst_ff) : dec(dst_ff);
            end
            if ((left_ff == '0) && pend_ff) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (fin_wr_ff) begin
               we    = 1'b1;
               waddr = fin_addr_ff;
               wdata = fin_val_ff;
            end
            rsp_val_in   = res_ff;
            rsp_st_in    = ST_OK;
            rsp_cnt_in   = COUNT_W'(count_ff);
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= pend_in;
      end
   end

   // work registers
   always_ff @(posedge clock) begin
      src_ff      <= src_in;
      dst_ff      <= dst_in;
      up_ff       <= up_in;
      left_ff     <= left_in;
      fin_addr_ff <= fin_addr_in;
      fin_wr_ff   <= fin_wr_in;
      fin_val_ff  <= fin_val_in;
      rd_only_ff  <= rd_only_in;
      res_ff      <= res_in;
      rsp_val_ff  <= rsp_val_in;
      rsp_cnt_ff  <= rsp_cnt_in;
      rsp_st_ff   <= rsp_st_in;
   end

   // element store, one write and one registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.read_value = rsp_val_ff;
   assign rsp_if.count      = rsp_cnt_ff;
   assign rsp_if.status     = rsp_st_ff;

endmodule

// ----- hw/rtl/double_ended_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded deque of signed words in a circular store, with positional insert,
// erase, read and write.
//
// channel  dir  words
// req_if   in   mode, index, value
// rsp_if   out  read_value, count, status
//
// Refused requests, clear, write, unused mode: answered straight from idle.
// Push: finish step. Read: look-up step. Insert: shift, then finish. Erase:
// look-up, shift, then finish. Insert and erase skip the shift when nothing
// moves. At most CAPACITY/2 elements move, one per cycle through the write port.
// Reset clears head and count; the store itself is not cleared.
// A two-word command queue takes up to two requests while a response stalls.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module double_ended_queue #(
   parameter int unsigned CAPACITY   = dq_pkg::DQ_CAPACITY,
   parameter int unsigned DATA_WIDTH = dq_pkg::DQ_DATA_WIDTH
) (
   input logic        clock,
   input logic        reset,
   dq_req_if.sink     req_if,
   dq_rsp_if.source   rsp_if
);
   import dq_pkg::*;

   localparam int unsigned CW = $clog2(CAPACITY + 1);

   dq_cmd_type    cmd;
   logic          cmd_valid, cmd_ready;
   logic [CW-1:0] occupancy;
   logic          rsp_full, rsp_empty;

   // accept and classify
   dq_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd       (cmd)
   );

   // execute against the store
   dq_back #(
      .CAPACITY   (CAPACITY),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd       (cmd),
      .rsp_if    (rsp_if),
      .occupancy (occupancy)
   );

   // refusals seen on the response channel
   assign rsp_full  = rsp_if.valid && (rsp_if.status == ST_FULL);
   assign rsp_empty = rsp_if.valid && (rsp_if.status == ST_EMPTY);

   // checks
   `DQ_ASSERT_ALWAYS(a_occ_bound, clock, reset, occupancy <= CAPACITY)
   `DQ_ASSERT_IMPL(a_full_at_cap, clock, reset, rsp_full, occupancy == CW'(CAPACITY))
   `DQ_ASSERT_IMPL(a_empty_zero, clock, reset, rsp_empty, occupancy == '0)

endmodule
